// ----- rtl/vfr_pkg.sv -----
// Shared types and constants for the video frame resync block.
package vfr_pkg;

  localparam int PIXEL_W    = 24;
  localparam int CNT_W      = 32;
  localparam int GEOM_W     = 16;
  localparam int CFG_ADDR_W = 8;

  localparam logic [CNT_W-1:0]  CNT_MAX         = {CNT_W{1'b1}};
  localparam logic [GEOM_W-1:0] ROWS_RESET      = 16'd1080;
  localparam logic [GEOM_W-1:0] COLS_RESET      = 16'd1920;

  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_ROWS = 8'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_COLS = 8'd1;

  typedef struct packed {
    logic [CNT_W-1:0] eol_err_total;
    logic [CNT_W-1:0] drop_total;
    logic [CNT_W-1:0] resync_total;
    logic [CNT_W-1:0] frame_total;
  } stats_t;

  localparam int OUT_DATA_W = PIXEL_W + 4 * CNT_W;

endpackage

// ----- rtl/vfr_sat_ctr.sv -----
// Saturating event counter with look-ahead of its next value.
module vfr_sat_ctr
  import vfr_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             inc,
  output logic [CNT_W-1:0] count,
  output logic [CNT_W-1:0] count_next
);

  always_comb begin
    count_next = count;
    if (inc && count != CNT_MAX) begin
      count_next = count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

endmodule

// ----- rtl/video_frame_resync.sv -----
// Video frame resync: one pixel per clock. Beats are dropped and counted until the first
// start-of-frame; after that start-of-frame and end-of-line are regenerated from internal
// column and row counters set by frame_rows and frame_cols. Each word leaves one input word
// late through a holding register, so the first locked word gives no output and a word is
// emitted for every later one. A word is taken on every clock unless the output register is
// full and stalled; throughput is one word per cycle, set by the single output register. An
// out-of-place start-of-frame restarts the raster and forces end-of-line on the held word.
// Frame, resync, drop and end-of-line-mismatch counts saturate at all ones and are
// republished on each frame's last pixel; every output word carries the published snapshot.
module video_frame_resync
  import vfr_pkg::*;
#(
  parameter int DATA_WIDTH = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [GEOM_W-1:0]     cfg_data,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [PIXEL_W-1:0]    s_axis_tdata,  // pixel_data
  input  logic                  s_axis_tuser,  // in_sof
  input  logic                  s_axis_tlast,  // in_eol
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // out_data, frame count, resync count, drop count, end-of-line mismatch count
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tuser,  // out_sof
  output logic                  m_axis_tlast   // out_eol
);

  localparam int KEEP_W = (DATA_WIDTH < PIXEL_W) ? DATA_WIDTH : PIXEL_W;

  logic [GEOM_W-1:0] frame_rows;
  logic [GEOM_W-1:0] frame_cols;

  logic              locked;
  logic [GEOM_W-1:0] col_pos;
  logic [GEOM_W-1:0] row_pos;
  logic [KEEP_W-1:0] held_data;
  logic              held_sof;
  logic              held_eol;
  logic              held_valid;
  stats_t            published;

  logic                  out_valid;
  logic [OUT_DATA_W-1:0] out_word;
  logic                  out_sof;
  logic                  out_eol;

  logic              accept;
  logic              proc;
  logic              resync;
  logic              at_last_col;
  logic              at_last_row;
  logic              frame_end;
  logic              miss;
  logic [GEOM_W-1:0] col_eff;
  logic [GEOM_W-1:0] row_eff;
  logic [GEOM_W-1:0] last_col;
  logic [GEOM_W-1:0] last_row;
  stats_t            cnt;
  stats_t            cnt_next;
  stats_t            pub_next;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_word;
  assign m_axis_tuser  = out_sof;
  assign m_axis_tlast  = out_eol;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_rows <= ROWS_RESET;
      frame_cols <= COLS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_addr == REG_FRAME_ROWS) begin
        frame_rows <= cfg_data;
      end else if (cfg_addr == REG_FRAME_COLS) begin
        frame_cols <= cfg_data;
      end
    end
  end

  // Raster decode for the incoming word.
  always_comb begin
    last_col    = frame_cols - GEOM_W'(1);
    last_row    = frame_rows - GEOM_W'(1);
    proc        = locked || s_axis_tuser;
    resync      = locked && s_axis_tuser && !(col_pos == '0 && row_pos == '0);
    col_eff     = (!locked || resync) ? '0 : col_pos;
    row_eff     = (!locked || resync) ? '0 : row_pos;
    at_last_col = (col_eff == last_col);
    at_last_row = (row_eff == last_row);
    frame_end   = proc && at_last_col && at_last_row;
    miss        = proc && (s_axis_tlast != at_last_col);
  end

  vfr_sat_ctr u_frames (
    .clk, .rst, .inc(accept && frame_end),
    .count(cnt.frame_total), .count_next(cnt_next.frame_total)
  );
  vfr_sat_ctr u_resync (
    .clk, .rst, .inc(accept && resync),
    .count(cnt.resync_total), .count_next(cnt_next.resync_total)
  );
  vfr_sat_ctr u_drops (
    .clk, .rst, .inc(accept && !proc),
    .count(cnt.drop_total), .count_next(cnt_next.drop_total)
  );
  vfr_sat_ctr u_eol_miss (
    .clk, .rst, .inc(accept && miss),
    .count(cnt.eol_err_total), .count_next(cnt_next.eol_err_total)
  );

  assign pub_next = frame_end ? cnt_next : published;

  always_ff @(posedge clk) begin
    if (rst) begin
      locked     <= 1'b0;
      col_pos    <= '0;
      row_pos    <= '0;
      held_valid <= 1'b0;
      held_sof   <= 1'b0;
      held_eol   <= 1'b0;
      published  <= '0;
    end else if (accept && proc) begin
      locked     <= 1'b1;
      held_valid <= 1'b1;
      held_sof   <= (col_eff == '0 && row_eff == '0);
      held_eol   <= at_last_col;
      published  <= pub_next;
      if (at_last_col) begin
        col_pos <= '0;
        row_pos <= at_last_row ? '0 : row_eff + GEOM_W'(1);
      end else begin
        col_pos <= col_eff + GEOM_W'(1);
        row_pos <= row_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && proc) begin
      held_data <= s_axis_tdata[KEEP_W-1:0];
    end
  end

  // Output register: load the held word, drop it once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && proc && held_valid) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && proc && held_valid) begin
      out_word <= {pub_next, PIXEL_W'(held_data)};
      out_sof  <= held_sof;
      out_eol  <= held_eol || resync;
    end
  end

`ifndef SYNTH
  a_out_needs_accept: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(accept))
    else $error("output word appeared without an accepted input word");

  a_held_needs_lock: assert property (@(posedge clk) disable iff (rst)
    !locked |-> !held_valid && !m_axis_tvalid)
    else $error("word held or emitted before lock");

  a_publish_on_frame: assert property (@(posedge clk) disable iff (rst)
    accept && frame_end |=> published == cnt)
    else $error("snapshot not published on frame end");
`endif

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for video_frame_resync: streams beats and checks every output word.
module tb_top;
  import vfr_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] REG_SPARE = 8'd2;
  localparam int FRAME_CAP = 60;
  localparam int ITEM_GOAL = 1100;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic               sof;
    logic               eol;
  } beat_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic               sof;
    logic               eol;
    stats_t             stats;
  } word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [GEOM_W-1:0]     cfg_data = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [PIXEL_W-1:0]    s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  s_axis_tlast = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  m_axis_tlast;

  video_frame_resync uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Resync state as the block should hold it
  logic [GEOM_W-1:0]  rows_cfg = ROWS_RESET;
  logic [GEOM_W-1:0]  cols_cfg = COLS_RESET;
  logic               locked = 1'b0;
  logic [GEOM_W-1:0]  col_pos = '0;
  logic [GEOM_W-1:0]  row_pos = '0;
  logic [CNT_W-1:0]   frame_cnt = '0;
  logic [CNT_W-1:0]   resync_cnt = '0;
  logic [CNT_W-1:0]   drop_cnt = '0;
  logic [CNT_W-1:0]   eol_miss_cnt = '0;
  logic [PIXEL_W-1:0] held_pixel = '0;
  logic               held_sof = 1'b0;
  logic               held_eol = 1'b0;
  logic               held_valid = 1'b0;
  stats_t             published = '0;

  beat_t beats_pending[$];
  word_t expected_words[$];

  int beats_queued = 0;
  int beats_in = 0;
  int words_checked = 0;
  int settings_used = 0;
  int errors = 0;
  int gap_rate = 0;
  int stall_rate = 0;
  int gap_left = 0;
  int stall_left = 0;
  logic beat_taken = 1'b0;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + CNT_W'(1);
  endfunction

  task automatic resync_step(input beat_t b);
    logic [GEOM_W-1:0] last_col;
    logic [GEOM_W-1:0] last_row;
    logic              at_last_col;
    logic              emitted;
    word_t             w;
    last_col = cols_cfg - GEOM_W'(1);
    last_row = rows_cfg - GEOM_W'(1);
    if (!locked) begin
      if (!b.sof) begin
        drop_cnt = sat_inc(drop_cnt);
        return;
      end
      locked = 1'b1;
      col_pos = '0;
      row_pos = '0;
    end
    if (b.sof && !(col_pos == '0 && row_pos == '0)) begin
      resync_cnt = sat_inc(resync_cnt);
      if (held_valid) held_eol = 1'b1;
      col_pos = '0;
      row_pos = '0;
    end
    at_last_col = (col_pos == last_col);
    if (b.eol != at_last_col) eol_miss_cnt = sat_inc(eol_miss_cnt);
    emitted = held_valid;
    w = '0;
    w.pixel = held_pixel;
    w.sof = held_sof;
    w.eol = held_eol;
    held_pixel = b.pixel;
    held_sof = (col_pos == '0 && row_pos == '0);
    held_eol = at_last_col;
    held_valid = 1'b1;
    if (at_last_col) begin
      col_pos = '0;
      if (row_pos == last_row) begin
        row_pos = '0;
        frame_cnt = sat_inc(frame_cnt);
        published.frame_total = frame_cnt;
        published.resync_total = resync_cnt;
        published.drop_total = drop_cnt;
        published.eol_err_total = eol_miss_cnt;
      end else begin
        row_pos = row_pos + GEOM_W'(1);
      end
    end else begin
      col_pos = col_pos + GEOM_W'(1);
    end
    if (emitted) begin
      w.stats = published;
      expected_words.push_back(w);
    end
  endtask

  task automatic check_field(input string what, input logic [CNT_W-1:0] want,
                             input logic [CNT_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      errors++;
    end
  endtask

  always @(negedge clk) begin : driver
    beat_t b;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      m_axis_tready <= 1'b0;
    end else begin
      if (!s_axis_tvalid || beat_taken) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (beats_pending.size() > 0) begin
          b = beats_pending.pop_front();
          s_axis_tdata <= b.pixel;
          s_axis_tuser <= b.sof;
          s_axis_tlast <= b.eol;
          s_axis_tvalid <= 1'b1;
          if ($urandom_range(15) < gap_rate) gap_left = $urandom_range(1, 10);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(15) < stall_rate) stall_left = $urandom_range(1, 10);
      end
    end
  end

  always @(posedge clk) begin : monitor
    beat_t  seen;
    word_t  want;
    stats_t got;
    beat_taken = !rst && s_axis_tvalid && s_axis_tready;
    if (beat_taken) begin
      seen.pixel = s_axis_tdata;
      seen.sof = s_axis_tuser;
      seen.eol = s_axis_tlast;
      resync_step(seen);
      beats_in++;
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected output word, expected none, got %0h", $time, m_axis_tdata);
        errors++;
      end else begin
        want = expected_words.pop_front();
        got = m_axis_tdata[OUT_DATA_W-1:PIXEL_W];
        check_field("out_data", CNT_W'(want.pixel), CNT_W'(m_axis_tdata[PIXEL_W-1:0]));
        check_field("out_sof", CNT_W'(want.sof), CNT_W'(m_axis_tuser));
        check_field("out_eol", CNT_W'(want.eol), CNT_W'(m_axis_tlast));
        check_field("frame count", want.stats.frame_total, got.frame_total);
        check_field("resync count", want.stats.resync_total, got.resync_total);
        check_field("drop count", want.stats.drop_total, got.drop_total);
        check_field("eol mismatch count", want.stats.eol_err_total, got.eol_err_total);
        words_checked++;
      end
    end
  end

  task automatic push_beat(input logic [PIXEL_W-1:0] px, input logic sof, input logic eol);
    beat_t b;
    b.pixel = px;
    b.sof = sof;
    b.eol = eol;
    beats_pending.push_back(b);
    beats_queued++;
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [GEOM_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_FRAME_ROWS) rows_cfg = val;
    else if (idx == REG_FRAME_COLS) cols_cfg = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_geometry(input logic [GEOM_W-1:0] rows, input logic [GEOM_W-1:0] cols);
    if ($urandom_range(1)) begin
      write_reg(REG_FRAME_ROWS, rows);
      write_reg(REG_FRAME_COLS, cols);
    end else begin
      write_reg(REG_FRAME_COLS, cols);
      write_reg(REG_FRAME_ROWS, rows);
    end
    settings_used++;
  endtask

  // Hold the sender until the block has returned everything it owes
  task automatic drain;
    while (beats_pending.size() != 0 || s_axis_tvalid) @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic queue_frames(input int nfr, input int rows, input int cols, input int err_pct);
    logic sof;
    logic eol;
    int   n;
    for (int f = 0; f < nfr; f++) begin
      n = 0;
      for (int r = 0; r < rows && n < FRAME_CAP; r++) begin
        for (int c = 0; c < cols && n < FRAME_CAP; c++) begin
          sof = (r == 0 && c == 0);
          eol = (c == cols - 1);
          n++;
          if ($urandom_range(99) < err_pct) begin
            case ($urandom_range(2))
              0: sof = ~sof;
              1: eol = ~eol;
              default: continue;
            endcase
          end
          push_beat(PIXEL_W'($urandom()), sof, eol);
        end
      end
    end
  endtask

  function automatic logic [GEOM_W-1:0] extreme_size();
    case ($urandom_range(2))
      0: return 16'd1;
      1: return 16'd0;
      default: return 16'hFFFF;
    endcase
  endfunction

  initial begin : stimulus
    logic [GEOM_W-1:0] rows;
    logic [GEOM_W-1:0] cols;
    int                rows_eff;
    int                cols_eff;
    int                sel;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset geometry: drops before lock, lock, extremes, mid-line start-of-frame
    push_beat(24'h123456, 1'b0, 1'b1);
    push_beat(24'hFFFFFF, 1'b0, 1'b0);
    push_beat(24'h000000, 1'b1, 1'b0);
    push_beat(24'hFFFFFF, 1'b0, 1'b1);
    push_beat(24'hABCDEF, 1'b1, 1'b0);
    push_beat(24'h5A5A5A, 1'b0, 1'b0);
    drain();

    set_geometry(16'd2, 16'd3);
    push_beat(24'hA5A5A5, 1'b1, 1'b0);
    push_beat(24'h000001, 1'b0, 1'b0);
    push_beat(24'h800000, 1'b0, 1'b1);
    push_beat(24'h555555, 1'b0, 1'b0);
    push_beat(24'hAAAAAA, 1'b0, 1'b0);
    push_beat(24'h7FFFFF, 1'b0, 1'b1);
    push_beat(24'h0F0F0F, 1'b1, 1'b0);
    push_beat(24'hF0F0F0, 1'b0, 1'b1);
    push_beat(24'h3C3C3C, 1'b0, 1'b1);
    push_beat(24'hC3C3C3, 1'b1, 1'b0);
    drain();

    write_reg(REG_SPARE, 16'h0001);
    set_geometry(16'd1, 16'd1);
    push_beat(24'h111111, 1'b1, 1'b1);
    push_beat(24'h222222, 1'b1, 1'b0);
    drain();

    set_geometry(16'd0, 16'd0);
    push_beat(24'h333333, 1'b0, 1'b0);
    push_beat(24'h444444, 1'b1, 1'b0);
    push_beat(24'h666666, 1'b0, 1'b1);
    drain();

    set_geometry(16'hFFFF, 16'hFFFF);
    push_beat(24'h777777, 1'b1, 1'b0);
    push_beat(24'h888888, 1'b0, 1'b0);
    push_beat(24'h999999, 1'b0, 1'b1);
    drain();

    while (beats_queued < ITEM_GOAL) begin
      sel = $urandom_range(9);
      if (sel == 0) begin
        rows = extreme_size();
        cols = GEOM_W'($urandom_range(1, 6));
      end else if (sel == 1) begin
        rows = GEOM_W'($urandom_range(1, 4));
        cols = extreme_size();
      end else begin
        rows = GEOM_W'($urandom_range(1, 5));
        cols = GEOM_W'($urandom_range(1, 8));
      end
      if ($urandom_range(3) == 0) write_reg(REG_SPARE, GEOM_W'($urandom()));
      set_geometry(rows, cols);
      if (beats_queued > ITEM_GOAL - 200) begin
        gap_rate = 0;
        stall_rate = 0;
      end else begin
        gap_rate = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
        stall_rate = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
      end
      rows_eff = (rows == '0) ? 65536 : int'(rows);
      cols_eff = (cols == '0) ? 65536 : int'(cols);
      sel = $urandom_range(9);
      if (sel == 0) begin
        repeat ($urandom_range(20, 40))
          push_beat(PIXEL_W'($urandom()), $urandom_range(7) == 0, 1'($urandom_range(1)));
      end else begin
        queue_frames($urandom_range(1, 3), rows_eff, cols_eff, (sel < 4) ? 10 : 0);
      end
      drain();
    end

    $display("Drove %0d input words across %0d geometry settings; checked %0d output words.",
             beats_in, settings_used, words_checked);
    $display("Frames %0d, resyncs %0d, dropped before lock %0d, end-of-line mismatches %0d.",
             frame_cnt, resync_cnt, drop_cnt, eol_miss_cnt);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("Timeout with %0d words still expected", expected_words.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
